### hw/rtl/assert_macros.svh
// Assertion macros shared by the selector RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TKNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define TKNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define TKNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TKNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/tkns_pkg.sv
// Shared types, constants and helpers of the k-nearest selector.
`timescale 1ns / 1ps
`default_nettype none

package tkns_pkg;

	localparam int K_MAX_DEF = 16;
	localparam int IDX_W     = 16;
	localparam int DIST_W    = 32;
	localparam int K_SEL_W   = 5;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// Register byte addresses and word indexes.
	localparam logic [ADDR_W-1:0] ADDR_K_SELECT = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_SKIP     = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_REL      = 4'h8;
	localparam logic [1:0] REG_K_SELECT = 2'd0;
	localparam logic [1:0] REG_SKIP     = 2'd1;
	localparam logic [1:0] REG_REL      = 2'd2;

	typedef struct packed {
		logic signed [DIST_W-1:0] cand_distance;
		logic [IDX_W-1:0]         cand_index;
		logic [IDX_W-1:0]         query_id;
		logic                     scan_end;
	} in_word_t;

	typedef struct packed {
		logic [3:0]               rank_pos;
		logic [IDX_W:0]           neighbor_id;
		logic signed [DIST_W-1:0] neighbor_dist;
		logic                     final_flag;
		logic                     status;
	} out_word_t;

	// One kept neighbor.
	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic [IDX_W-1:0]         idx;
	} entry_t;

	// Snapshot control from the sorting chain to the output chain.
	typedef struct packed {
		logic load;
		logic err;
	} snap_ctl_t;

	// Smaller distance wins; on equal distance the lower index wins.
	function automatic logic better(input entry_t a, input entry_t b);
		logic res;
		if (a.distance != b.distance) begin
			res = (a.distance < b.distance);
		end else begin
			res = (a.idx < b.idx);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tkns_sort_cell.sv
// One cell of the sorted insertion chain: holds a single kept neighbor.
`timescale 1ns / 1ps
`default_nettype none

module tkns_sort_cell
	import tkns_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   ins_en,
	input  wire logic   live,
	input  wire entry_t cand,
	input  wire logic   prev_gt,
	input  wire entry_t prev_ent,
	output logic        gt,
	output entry_t      ent_q,
	output entry_t      ent_snap
);

	entry_t ent_nxt;

	// The candidate beats this entry, or this slot is empty.
	assign gt = live ? better(cand, ent_q) : 1'b1;

	// Keep, take the left neighbor's entry, or take the candidate.
	always_comb begin
		if (!gt) begin
			ent_nxt = ent_q;
		end else if (prev_gt) begin
			ent_nxt = prev_ent;
		end else begin
			ent_nxt = cand;
		end
	end

	assign ent_snap = ins_en ? ent_nxt : ent_q;

	always_ff @(posedge clk) begin
		ent_q <= ent_snap;
	end

endmodule

`default_nettype wire

### hw/rtl/tkns_out_chain.sv
// Output chain: a snapshot of the sorted list that shifts out one word per handshake.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tkns_out_chain
	import tkns_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire snap_ctl_t                    ctl,
	input  wire logic [$clog2(K_MAX+1)-1:0]   load_cnt,
	input  wire entry_t                       load_ent [K_MAX],
	input  wire logic                         rel_mode,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output out_word_t                         out_data,
	output logic                              busy
);

	localparam int CW = $clog2(K_MAX + 1);
	localparam int RW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	entry_t                  cell_q [K_MAX];
	logic signed [DIST_W-1:0] base_q;
	logic [CW-1:0]           count_q;
	logic [RW-1:0]           rank_q;
	logic                    err_q;
	logic                    take;
	logic signed [DIST_W:0]  diff;
	logic [31:0]             rank_ext;

	// The chain can take a new snapshot in the cycle its last word leaves.
	assign out_valid = (count_q != '0);
	assign take      = out_valid && out_ready;
	assign busy      = out_valid && !(take && (count_q == CW'(1)));

	// Word counter, rank counter and error flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rank_q  <= '0;
			err_q   <= 1'b0;
		end else if (ctl.load) begin
			count_q <= ctl.err ? CW'(1) : load_cnt;
			rank_q  <= '0;
			err_q   <= ctl.err;
		end else if (take) begin
			count_q <= count_q - CW'(1);
			rank_q  <= rank_q + RW'(1);
		end
	end

	// Cells load in parallel and shift toward the head.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_q <= load_ent[0].distance;
			for (int i = 0; i < K_MAX; i++) begin
				cell_q[i] <= load_ent[i];
			end
		end else if (take) begin
			for (int i = 0; i < K_MAX - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	// Relative distance with a floor of zero and saturation at the top.
	assign diff     = {cell_q[0].distance[DIST_W-1], cell_q[0].distance}
		- {base_q[DIST_W-1], base_q};
	assign rank_ext = 32'(rank_q);

	always_comb begin
		out_data            = '0;
		out_data.final_flag = (count_q == CW'(1));
		out_data.status     = err_q;
		if (!err_q) begin
			out_data.rank_pos    = rank_ext[3:0];
			out_data.neighbor_id = {1'b0, cell_q[0].idx} + (IDX_W+1)'(1);
			if (!rel_mode) begin
				out_data.neighbor_dist = cell_q[0].distance;
			end else if (diff[DIST_W]) begin
				out_data.neighbor_dist = '0;
			end else if (diff[DIST_W-1]) begin
				out_data.neighbor_dist = {1'b0, {(DIST_W-1){1'b1}}};
			end else begin
				out_data.neighbor_dist = diff[DIST_W-1:0];
			end
		end
	end

	`TKNS_ASSERT_IMPL(a_err_is_final, clk, arst_n, out_valid && out_data.status, out_data.final_flag)
	`TKNS_ASSERT_IMPL(a_load_when_idle, clk, arst_n, ctl.load, !busy)

endmodule

`default_nettype wire

### hw/rtl/top_k_nearest_selector_unit.sv
// Top level of the streaming k-nearest selector: register port, sorting chain, output chain.
//
// Usage: candidates arrive on in_valid/in_ready/in_data, one word per cycle while
// in_ready is high. Each word is compared against every kept entry at once in
// a row of sort cells and inserted at the edge that takes it.
// When a word with scan_end is taken, the sorted list (including that word if it
// is kept) is copied into the output chain in the same edge and the kept list is
// cleared; the next scan may start in the following cycle.
// Results leave on out_valid/out_ready/out_data: the first one is valid in the
// cycle after the scan_end word is taken, then one word per cycle while
// out_ready is high: k words, or a single status word if fewer than k
// candidates were kept. A scan_end word is held off (in_ready low) while the
// output chain still holds words of the previous scan, unless its last word
// leaves in the same cycle; other words keep flowing, so a stalled receiver
// only blocks the end of the next scan.
// Registers are written through the APB-style port; the user must write them only while
// idle, which the block does not enforce. Reset clears the kept-list fill count, the output
// chain, skip_self and relative_mode and sets k_select to one; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module top_k_nearest_selector_unit
	import tkns_pkg::*;
#(
	parameter int K_MAX = K_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_word_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_word_t              out_data
);

	localparam int CW = $clog2(K_MAX + 1);

	logic [K_SEL_W-1:0] k_q;
	logic               skip_q;
	logic               rel_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      k_eff;
	logic [CW-1:0]      n_w;
	logic [CW-1:0]      n_after;
	logic [K_MAX-1:0]   gt_w;
	logic [K_MAX-1:0]   live_w;
	entry_t             ent_q_w   [K_MAX];
	entry_t             ent_snap_w[K_MAX];
	entry_t             cand;
	logic               acc;
	logic               self_hit;
	logic               do_ins;
	logic               has_room;
	logic               drain_busy;
	snap_ctl_t          ctl;

	// Register port: writes decode the word index, reads need the exact address.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= K_SEL_W'(1);
			skip_q <= 1'b0;
			rel_q  <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_K_SELECT: k_q    <= pwdata[K_SEL_W-1:0];
				REG_SKIP:     skip_q <= pwdata[0];
				REG_REL:      rel_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_K_SELECT: prdata = DATA_W'(k_q);
			ADDR_SKIP:     prdata = DATA_W'(skip_q);
			ADDR_REL:      prdata = DATA_W'(rel_q);
			default:       prdata = '0;
		endcase
	end

	// Effective k, clamped to one through K_MAX.
	always_comb begin
		if (k_q == '0) begin
			k_eff = CW'(1);
		end else if (int'(k_q) > K_MAX) begin
			k_eff = CW'(K_MAX);
		end else begin
			k_eff = CW'(k_q);
		end
	end

	// Entries past the current k are treated as dropped.
	assign n_w = (fill_q > k_eff) ? k_eff : fill_q;

	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			live_w[i] = (i < int'(n_w));
		end
	end

	assign cand.distance = in_data.cand_distance;
	assign cand.idx      = in_data.cand_index;

	// Handshake and insertion decision.
	assign in_ready = !(in_data.scan_end && drain_busy);
	assign acc      = in_valid && in_ready;
	assign self_hit = skip_q && (in_data.cand_index == in_data.query_id);
	assign has_room = (n_w < k_eff);
	assign do_ins   = acc && !self_hit && (has_room || (|(gt_w & live_w)));
	assign n_after  = (do_ins && has_room) ? n_w + CW'(1) : n_w;

	// A candidate that is not skipped also cuts the list to the current k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc && in_data.scan_end) begin
			fill_q <= '0;
		end else if (acc && !self_hit) begin
			fill_q <= n_after;
		end
	end

	// Sorting chain: each cell compares the candidate with its own entry and uses its left neighbor's result.
	for (genvar g = 0; g < K_MAX; g++) begin : g_cell
		tkns_sort_cell u_cell (
			.clk      (clk),
			.ins_en   (do_ins),
			.live     (live_w[g]),
			.cand     (cand),
			.prev_gt  ((g == 0) ? 1'b0 : gt_w[(g == 0) ? 0 : g-1]),
			.prev_ent (ent_q_w[(g == 0) ? 0 : g-1]),
			.gt       (gt_w[g]),
			.ent_q    (ent_q_w[g]),
			.ent_snap (ent_snap_w[g])
		);
	end

	// Snapshot of the list at scan end.
	assign ctl.load = acc && in_data.scan_end;
	assign ctl.err  = (n_after < k_eff);

	tkns_out_chain #(
		.K_MAX (K_MAX)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.load_cnt  (k_eff),
		.load_ent  (ent_snap_w),
		.rel_mode  (rel_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.busy      (drain_busy)
	);

	`TKNS_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, int'(fill_q) <= K_MAX)
	`TKNS_ASSERT_NEXT(a_end_clears, clk, arst_n, acc && in_data.scan_end, fill_q == '0)
	`TKNS_ASSERT_NEXT(a_fill_step, clk, arst_n, acc && !in_data.scan_end, int'(fill_q) <= int'($past(fill_q)) + 1)

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the k-nearest selector: directed and random candidate words.
`timescale 1ns / 1ps

module tb_top;
	import tkns_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 46;
	localparam int N_PHASES    = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	in_word_t          in_data;
	logic              out_valid;
	logic              out_ready;
	out_word_t         out_data;

	// Neighbor counts used by the random phases, out-of-range values among them.
	int unsigned k_plan [N_PHASES] = '{16, 1, 5, 0, 31, 3, 17, 9};

	bit idle_on;
	int quiet_cycles;

	// Keeps a sorted copy of the best candidates and the neighbor words they must produce.
	class topk_scoreboard;
		logic signed [DIST_W-1:0] kept_dist [K_MAX_DEF];
		logic [IDX_W-1:0]         kept_idx [K_MAX_DEF];
		int unsigned              kept_n;
		logic [K_SEL_W-1:0]       k_sel;
		logic                     skip_en;
		logic                     rel_en;
		out_word_t                neighbor_q [$];
		int                       errors;

		function new();
			k_sel   = 1;
			skip_en = 1'b0;
			rel_en  = 1'b0;
			kept_n  = 0;
			errors  = 0;
			foreach (kept_dist[i]) begin
				kept_dist[i] = '0;
				kept_idx[i]  = '0;
			end
		endfunction

		function void set_reg(input logic [1:0] which, input logic [DATA_W-1:0] val);
			case (which)
				REG_K_SELECT: k_sel = val[K_SEL_W-1:0];
				REG_SKIP: skip_en = val[0];
				REG_REL: rel_en = val[0];
				default: ;
			endcase
		endfunction

		// A zero count acts as one, and counts above the list size act as the list size.
		function int unsigned active_k();
			if (k_sel == 0) return 1;
			if (k_sel > K_MAX_DEF) return K_MAX_DEF;
			return 32'(k_sel);
		endfunction

		// Sorted insertion; a candidate that only ties the worst entry of a full list is dropped.
		function void insert_candidate(input logic signed [DIST_W-1:0] d,
				input logic [IDX_W-1:0] idx, input int unsigned k);
			int unsigned n;
			int unsigned pos;
			n = (kept_n > k) ? k : kept_n;
			pos = 0;
			while (pos < n && (kept_dist[pos] < d ||
					(kept_dist[pos] == d && kept_idx[pos] <= idx))) begin
				pos++;
			end
			if (n >= k) begin
				if (pos >= k) begin
					kept_n = n;
					return;
				end
				n = k - 1;
			end
			for (int unsigned j = n; j > pos; j--) begin
				kept_dist[j] = kept_dist[j-1];
				kept_idx[j]  = kept_idx[j-1];
			end
			kept_dist[pos] = d;
			kept_idx[pos]  = idx;
			kept_n = n + 1;
		endfunction

		function void note_candidate(input in_word_t w);
			int unsigned k;
			int unsigned n;
			longint r;
			out_word_t e;
			k = active_k();
			if (!(skip_en && w.cand_index == w.query_id)) begin
				insert_candidate(w.cand_distance, w.cand_index, k);
			end
			if (!w.scan_end) return;
			n = (kept_n > k) ? k : kept_n;
			kept_n = 0;
			// A short scan yields a single status word.
			if (n < k) begin
				e = '0;
				e.final_flag = 1'b1;
				e.status = 1'b1;
				neighbor_q = {neighbor_q, e};
				return;
			end
			for (int unsigned j = 0; j < k; j++) begin
				r = longint'(kept_dist[j]);
				if (rel_en) begin
					r = r - longint'(kept_dist[0]);
					if (r < 0) r = 0;
					if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
				end
				e.rank_pos      = 4'(j);
				e.neighbor_id   = 17'(kept_idx[j]) + 17'd1;
				e.neighbor_dist = r[31:0];
				e.final_flag    = (j == k - 1);
				e.status        = 1'b0;
				neighbor_q = {neighbor_q, e};
			end
		endfunction

		function void compare_field(input string fname, input logic [31:0] want,
				input logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
				errors++;
			end
		endfunction

		function void check_neighbor(input out_word_t got);
			out_word_t want;
			if (neighbor_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = neighbor_q.pop_front();
			compare_field("rank_pos", want.rank_pos, got.rank_pos);
			compare_field("neighbor_id", want.neighbor_id, got.neighbor_id);
			compare_field("neighbor_dist", want.neighbor_dist, got.neighbor_dist);
			compare_field("final_flag", want.final_flag, got.final_flag);
			compare_field("status", want.status, got.status);
		endfunction

		function int pending();
			return neighbor_q.size();
		endfunction

		function void close_out();
			if (neighbor_q.size() != 0) begin
				$display("%0t: missing results, expected %0d more words, actual 0", $time,
					neighbor_q.size());
				errors++;
			end
		endfunction
	endclass

	topk_scoreboard sb;

	top_k_nearest_selector_unit #(
		.K_MAX(K_MAX_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Results are checked before the candidate accepted at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_neighbor(out_data);
			if (in_valid && in_ready) sb.note_candidate(in_data);
		end
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver stalls in random bursts while idling is enabled.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Register write: setup cycle, then access cycle; returns after the bus is released and the scoreboard is updated.
	task automatic write_reg(input logic [1:0] which, input logic [DATA_W-1:0] val);
		logic [ADDR_W-1:0] addr;
		case (which)
			REG_K_SELECT: addr = ADDR_K_SELECT;
			REG_SKIP: addr = ADDR_SKIP;
			default: addr = ADDR_REL;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		sb.set_reg(which, val);
	endtask

	// Offers one candidate word, with an optional gap before it, and waits until it is taken.
	task automatic send(input logic [31:0] d, input logic [15:0] idx, input logic [15:0] qid,
			input logic last);
		in_word_t w;
		w.cand_distance = d;
		w.cand_index    = idx;
		w.query_id      = qid;
		w.scan_end      = last;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Holds the sender until every expected word has come, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One scan with random content; most are at least k long, some are cut short.
	task automatic random_scan(input int unsigned k, inout int count);
		int unsigned len;
		logic [15:0] qid;
		logic [15:0] idx;
		logic [31:0] d;
		int v;
		if ($urandom_range(0, 6) == 0) begin
			len = (k > 1) ? $urandom_range(1, k - 1) : 1;
		end else begin
			len = k + $urandom_range(0, 8);
		end
		qid = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: d = $urandom;
				1: begin
					v = int'($urandom_range(0, 6)) - 3;
					d = v <<< 16;
				end
				2: d = $urandom_range(0, 3);
				default: d = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			endcase
			idx = $urandom_range(0, 2) ? 16'($urandom_range(0, 15)) : 16'($urandom);
			send(d, idx, qid, i == len - 1);
		end
		count += len;
	endtask

	initial begin
		sb = new();
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_on  = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a single neighbor with the largest distance and index.
		send(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		drain();

		// The only candidate is the query itself, so the scan comes up short.
		write_reg(REG_SKIP, 32'd1);
		send(32'h8000_0000, 16'h1234, 16'h1234, 1'b1);
		drain();

		// Ties on distance, a skipped self match and a rejected worst candidate, relative.
		write_reg(REG_K_SELECT, 32'd3);
		write_reg(REG_REL, 32'd1);
		send(32'h0001_0000, 16'd9, 16'd0, 1'b0);
		send(32'h0001_0000, 16'd4, 16'd0, 1'b0);
		send(32'h8000_0000, 16'd0, 16'd0, 1'b0);
		send(32'hFFFF_0000, 16'hAAAA, 16'd0, 1'b0);
		send(32'h7FFF_FFFF, 16'h5555, 16'd0, 1'b1);
		drain();

		// Relative distance across the full range saturates.
		write_reg(REG_K_SELECT, 32'd2);
		write_reg(REG_SKIP, 32'd0);
		send(32'h8000_0000, 16'd5, 16'd7, 1'b0);
		send(32'h7FFF_FFFF, 16'd6, 16'd7, 1'b1);
		drain();

		// An exact tie with the worst entry of a full list is turned away.
		write_reg(REG_REL, 32'd0);
		send(32'd5, 16'd3, 16'd0, 1'b0);
		send(32'd5, 16'd4, 16'd0, 1'b0);
		send(32'd5, 16'd4, 16'd0, 1'b0);
		send(32'd5, 16'd2, 16'd0, 1'b0);
		send(32'd9, 16'd1, 16'd0, 1'b1);
		drain();

		// A count above the list size acts as the list size; three candidates are too few.
		write_reg(REG_K_SELECT, 32'd31);
		send(32'd1, 16'd1, 16'd0, 1'b0);
		send(32'd2, 16'd2, 16'd0, 1'b0);
		send(32'd3, 16'd3, 16'd0, 1'b1);
		drain();

		// The count is lowered in the middle of a scan; the list is cut before the last insert.
		write_reg(REG_K_SELECT, 32'd6);
		send(32'd50, 16'd10, 16'd0, 1'b0);
		send(32'd40, 16'd11, 16'd0, 1'b0);
		send(32'd30, 16'd12, 16'd0, 1'b0);
		send(32'd20, 16'd13, 16'd0, 1'b0);
		send(32'd10, 16'd14, 16'd0, 1'b0);
		drain();
		write_reg(REG_K_SELECT, 32'd2);
		send(32'd25, 16'd15, 16'd0, 1'b1);
		drain();

		// A zero count acts as one.
		write_reg(REG_K_SELECT, 32'd0);
		send(32'hFFFF_FFFF, 16'd8, 16'd0, 1'b0);
		send(32'h0000_0000, 16'd7, 16'd0, 1'b1);

		// Random phases, each with its own settings; the third, the sixth and the last run without idling.
		for (int p = 0; p < N_PHASES; p++) begin
			int count;
			drain();
			idle_on = (p != 2 && p != 5 && p != N_PHASES - 1);
			write_reg(REG_K_SELECT, k_plan[p]);
			write_reg(REG_SKIP, $urandom_range(0, 1));
			write_reg(REG_REL, $urandom_range(0, 1));
			count = 0;
			while (count < PHASE_ITEMS) begin
				random_scan(sb.active_k(), count);
				if ($urandom_range(0, 7) == 0) drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
